@@ hw/rtl/rau_pkg.sv @@
// shared types and constants of the rational arithmetic unit
package rau_pkg;

  // operand field width and significant bits of each operand
  localparam int FIELD_W    = 32;
  localparam int DATA_WIDTH = 32;
  localparam int DEN_W      = FIELD_W - 1;

  // double-width products and the reduction engine
  localparam int PROD_W = 2 * FIELD_W;
  localparam int CNT_W  = $clog2(PROD_W);
  localparam int SHF_W  = $clog2(PROD_W);

  // magnitude limit of a signed DATA_WIDTH result
  localparam logic [PROD_W-1:0] LIM    = PROD_W'(1) << (DATA_WIDTH - 1);
  localparam logic [PROD_W-1:0] LIM_M1 = LIM - PROD_W'(1);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // numerator and denominator magnitudes at double width
  typedef struct packed {
    logic [PROD_W-1:0] num;
    logic [PROD_W-1:0] den;
  } rau_pair_t;

endpackage

@@ hw/rtl/rau_in_if.sv @@
// request channel: opcode and two fractions
interface rau_in_if;
  import rau_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           opcode;
  logic signed [FIELD_W-1:0] a_num;
  logic signed [FIELD_W-1:0] a_den;
  logic signed [FIELD_W-1:0] b_num;
  logic signed [FIELD_W-1:0] b_den;

  modport source (output valid, opcode, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, opcode, a_num, a_den, b_num, b_den, output ready);
endinterface

@@ hw/rtl/rau_out_if.sv @@
// result channel: reduced fraction and status
interface rau_out_if;
  import rau_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] res_num;
  logic [DEN_W-1:0]          res_den;
  status_t                   status;

  modport source (output valid, res_num, res_den, status, input ready);
  modport sink   (input valid, res_num, res_den, status, output ready);
endinterface

@@ hw/rtl/rational_arithmetic_unit_core.sv @@
// Rational arithmetic unit: adds, subtracts, multiplies or divides two signed
// fractions and returns the result reduced by its greatest common divisor, with
// the sign on the numerator. One request is worked at a time. A request first
// forms the three double-width products on the single 32x32 multiplier (one
// product per cycle) and then combines them; a zero result or a zero
// denominator skips the reduction. Otherwise the reduction engine runs the
// binary gcd steps (one shift or one 64-bit subtract or swap per cycle) and
// then the two restoring divisions at one bit a cycle. The input reopens in
// the cycle the result is offered. The result sits in an output register, so
// a finished result waits for the consumer without holding back the next
// request's arithmetic.
module rational_arithmetic_unit_core (
  input logic                clk,
  input logic                rst,
  rau_in_if.sink             req_in,
  rau_out_if.source          res_out
);
  import rau_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_COMB,
    S_RED,
    S_WRITE
  } state_t;

  localparam logic [1:0] MUL_LAST = 2'd2;

  state_t             state;
  opcode_t            op;
  logic               san, sad, sbn, sbd;
  logic [FIELD_W-1:0] man, mad, mbn, mbd;
  logic [1:0]         mstep;
  logic [PROD_W-1:0]  p0, p1, p2;
  logic               neg;
  logic               eng_start;
  rau_pair_t          eng_op;
  logic               eng_done;
  rau_pair_t          eng_quo;

  logic [FIELD_W-1:0] r_num;
  logic [DEN_W-1:0]   r_den;
  status_t            r_st;

  logic               out_valid;
  logic [FIELD_W-1:0] out_num;
  logic [DEN_W-1:0]   out_den;
  status_t            out_st;

  logic [FIELD_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0]  prod;
  logic               s1, s2, sd, sn;
  logic [PROD_W-1:0]  sum;
  logic               ge01;
  logic [PROD_W-1:0]  mn;
  logic               ovf;
  logic [FIELD_W-1:0] qn_low;

  // sign and magnitude of the low DATA_WIDTH bits of an operand
  function automatic logic [FIELD_W:0] split_op(input logic [FIELD_W-1:0] raw);
    logic [DATA_WIDTH-1:0] v;
    logic [DATA_WIDTH-1:0] mag;
    v   = raw[DATA_WIDTH-1:0];
    mag = v[DATA_WIDTH-1] ? (~v + DATA_WIDTH'(1)) : v;
    return {v[DATA_WIDTH-1], FIELD_W'(mag)};
  endfunction

  assign req_in.ready    = (state == S_IDLE);
  assign res_out.valid   = out_valid;
  assign res_out.res_num = out_num;
  assign res_out.res_den = out_den;
  assign res_out.status  = out_st;

  // shared multiplier operand select, one product per step
  always_comb begin
    case (mstep)
      2'd0: begin
        mul_a = man;
        mul_b = (op == OP_MUL) ? mbn : mbd;
      end
      2'd1: begin
        mul_a = mad;
        mul_b = mbn;
      end
      default: begin
        mul_a = mad;
        mul_b = (op == OP_DIV) ? mbn : mbd;
      end
    endcase
    prod = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // signs and signed-magnitude combine of the raw numerator
  always_comb begin
    s1   = (op == OP_MUL) ? (san ^ sbn) : (san ^ sbd);
    s2   = (sad ^ sbn) ^ (op == OP_SUB);
    sd   = (op == OP_DIV) ? (sad ^ sbn) : (sad ^ sbd);
    sum  = p0 + p1;
    ge01 = (p0 >= p1);
    if (op == OP_ADD || op == OP_SUB) begin
      if (s1 == s2) begin
        mn = sum;
        sn = s1;
      end else if (ge01) begin
        mn = p0 - p1;
        sn = s1;
      end else begin
        mn = p1 - p0;
        sn = s2;
      end
    end else begin
      mn = p0;
      sn = s1;
    end
  end

  // range check of the reduced fraction
  always_comb begin
    ovf    = (neg ? (eng_quo.num > LIM) : (eng_quo.num > LIM_M1)) || (eng_quo.den > LIM_M1);
    qn_low = eng_quo.num[FIELD_W-1:0];
  end

  rau_reduce u_reduce (
    .clk   (clk),
    .rst   (rst),
    .start (eng_start),
    .op_in (eng_op),
    .done  (eng_done),
    .quo   (eng_quo)
  );

  // control sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      eng_start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      eng_start <= (state == S_COMB) && (p2 != '0) && (mn != '0);
      if (out_valid && res_out.ready && state != S_WRITE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_in.valid) begin
            op           <= opcode_t'(req_in.opcode);
            {san, man}   <= split_op(req_in.a_num);
            {sad, mad}   <= split_op(req_in.a_den);
            {sbn, mbn}   <= split_op(req_in.b_num);
            {sbd, mbd}   <= split_op(req_in.b_den);
            mstep        <= '0;
            state        <= S_MUL;
          end
        end
        S_MUL: begin
          case (mstep)
            2'd0:    p0 <= prod;
            2'd1:    p1 <= prod;
            default: p2 <= prod;
          endcase
          mstep <= mstep + 2'd1;
          if (mstep == MUL_LAST) begin
            state <= S_COMB;
          end
        end
        S_COMB: begin
          neg <= sn ^ sd;
          if (p2 == '0) begin
            r_st  <= ST_ZERO_DEN;
            r_num <= '0;
            r_den <= '0;
            state <= S_WRITE;
          end else if (mn == '0) begin
            r_st  <= ST_OK;
            r_num <= '0;
            r_den <= DEN_W'(1);
            state <= S_WRITE;
          end else begin
            eng_op.num <= mn;
            eng_op.den <= p2;
            state      <= S_RED;
          end
        end
        S_RED: begin
          if (eng_done) begin
            if (ovf) begin
              r_st  <= ST_OVERFLOW;
              r_num <= '0;
              r_den <= '0;
            end else begin
              r_st  <= ST_OK;
              r_num <= neg ? (~qn_low + FIELD_W'(1)) : qn_low;
              r_den <= eng_quo.den[DEN_W-1:0];
            end
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (!out_valid || res_out.ready) begin
            out_valid <= 1'b1;
            out_num   <= r_num;
            out_den   <= r_den;
            out_st    <= r_st;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // engine start only as the sequencer waits for it
  a_start_in_red: assert property (@(posedge clk) disable iff (rst)
    eng_start |-> state == S_RED)
    else $error("reduction started outside the reduce state");

  // engine finishes only while the sequencer waits for it
  a_done_in_red: assert property (@(posedge clk) disable iff (rst)
    eng_done |-> state == S_RED)
    else $error("reduction finished with no request waiting");

  // a good result never has a zero denominator
  a_ok_den: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_st == ST_OK) |-> out_den != '0)
    else $error("ok result with zero denominator");

  // a taken request closes the input until its result is written
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_in.valid && req_in.ready) |=> state == S_MUL)
    else $error("request accepted without starting the products");

endmodule

@@ hw/rtl/rau_reduce.sv @@
// reduction engine: binary gcd, then two restoring divisions, on one 64-bit subtractor
module rau_reduce (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  rau_pkg::rau_pair_t  op_in,
  output logic                done,
  output rau_pkg::rau_pair_t  quo
);
  import rau_pkg::*;

  typedef enum logic [1:0] {
    R_IDLE,
    R_GCD,
    R_DIVN,
    R_DIVD
  } rstate_t;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PROD_W - 1);

  rstate_t           state;
  logic [PROD_W-1:0] x;
  logic [PROD_W-1:0] y;
  logic [SHF_W-1:0]  k;
  logic [PROD_W-1:0] g;
  logic [PROD_W-1:0] dv;
  logic [PROD_W-1:0] rem;
  logic [CNT_W-1:0]  cnt;
  logic [PROD_W-1:0] n_sav;
  logic [PROD_W-1:0] d_sav;

  logic [PROD_W:0]   op_a;
  logic [PROD_W:0]   op_b;
  logic [PROD_W+1:0] diff;
  logic              ge;
  logic [PROD_W-1:0] rem_next;
  logic [PROD_W-1:0] dv_next;

  // shared subtractor: gcd compares x with y, division trial-subtracts the divisor
  always_comb begin
    if (state == R_GCD) begin
      op_a = {1'b0, x};
      op_b = {1'b0, y};
    end else begin
      op_a = {rem, dv[PROD_W-1]};
      op_b = {1'b0, g};
    end
    diff     = {1'b0, op_a} - {1'b0, op_b};
    ge       = ~diff[PROD_W+1];
    rem_next = ge ? diff[PROD_W-1:0] : op_a[PROD_W-1:0];
    dv_next  = {dv[PROD_W-2:0], ge};
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == R_DIVD) && (cnt == CNT_LAST);
      case (state)
        R_IDLE: begin
          if (start) begin
            x     <= op_in.num;
            y     <= op_in.den;
            n_sav <= op_in.num;
            d_sav <= op_in.den;
            k     <= '0;
            state <= R_GCD;
          end
        end
        R_GCD: begin
          if (x == '0 || y == '0) begin
            g     <= (x | y) << k;
            dv    <= n_sav;
            rem   <= '0;
            cnt   <= '0;
            state <= R_DIVN;
          end else if (!x[0] && !y[0]) begin
            // common factor of two
            x <= x >> 1;
            y <= y >> 1;
            k <= k + SHF_W'(1);
          end else if (!x[0]) begin
            x <= x >> 1;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (ge) begin
            x <= diff[PROD_W-1:0];
          end else begin
            // keep the larger value in x
            x <= y;
            y <= x;
          end
        end
        R_DIVN: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_LAST) begin
            quo.num <= dv_next;
            dv      <= d_sav;
            rem     <= '0;
            state   <= R_DIVD;
          end else begin
            rem <= rem_next;
            dv  <= dv_next;
          end
        end
        R_DIVD: begin
          rem <= rem_next;
          dv  <= dv_next;
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_LAST) begin
            quo.den <= dv_next;
            state   <= R_IDLE;
          end
        end
        default: state <= R_IDLE;
      endcase
    end
  end

endmodule
